/* src/hpq_pkg.sv */
`timescale 1ns / 1ps

package hpq_pkg;

  // Fixed field widths of one word on either channel.
  localparam int KEY_W  = 64;
  localparam int TAG_W  = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // Default number of heap slots.
  localparam int CAPACITY_DEF = 64;

  // Operation codes on the input channel.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes on the result channel.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // One heap entry as it sits in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Flags from the shared key comparator.
  typedef struct packed {
    logic e_lt_a;   // moving entry below port A entry
    logic a_lt_e;   // port A entry below moving entry
    logic b_lt_e;   // port B entry below moving entry
    logic a_lt_b;   // port A entry below port B entry
  } cmp_t;

  // Result word handed from the sequencer to the output register.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [OCC_W-1:0]  occ;
  } res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_LOAD,
    S_SIFT_UP,
    S_SIFT_DN,
    S_FINISH
  } state_t;

endpackage

/* src/hpq_mem.sv */
`timescale 1ns / 1ps

module hpq_mem #(
  parameter int DEPTH = hpq_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  hpq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr_a,
  input  logic [AW-1:0]   raddr_b,
  output hpq_pkg::entry_t rdata_a,
  output hpq_pkg::entry_t rdata_b
);

  hpq_pkg::entry_t slot_mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= wdata;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk) begin
    rdata_a <= slot_mem[raddr_a];
    rdata_b <= slot_mem[raddr_b];
  end

endmodule

/* src/hpq_cmp.sv */
`timescale 1ns / 1ps

module hpq_cmp (
  input  logic [hpq_pkg::KEY_W-1:0] key_e,
  input  logic [hpq_pkg::KEY_W-1:0] key_a,
  input  logic [hpq_pkg::KEY_W-1:0] key_b,
  output hpq_pkg::cmp_t             flags
);

  // Four unsigned key compares side by side; the sequencer picks what it needs.
  always_comb begin
    flags.e_lt_a = key_e < key_a;
    flags.a_lt_e = key_a < key_e;
    flags.b_lt_e = key_b < key_e;
    flags.a_lt_b = key_a < key_b;
  end

endmodule

/* src/hpq_seq.sv */
`timescale 1ns / 1ps

module hpq_seq #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_op,
  input  logic [hpq_pkg::KEY_W-1:0] in_key,
  input  logic [hpq_pkg::TAG_W-1:0] in_tag,
  // result hand-off
  input  logic                      out_free,
  output logic                      res_load,
  output hpq_pkg::res_t             res,
  // slot memory
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output hpq_pkg::entry_t           mem_wdata,
  output logic [AW-1:0]             mem_raddr_a,
  output logic [AW-1:0]             mem_raddr_b,
  input  hpq_pkg::entry_t           mem_rdata_a,
  input  hpq_pkg::entry_t           mem_rdata_b
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  hpq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic            op_r, op_nxt;
  logic            wr_hole_r, wr_hole_nxt;
  hpq_pkg::entry_t ent_r, ent_nxt;
  hpq_pkg::res_t   res_r, res_nxt;

  hpq_pkg::cmp_t   flags;
  logic [IW-1:0]   lft, rgt, cnt_ext, nlft, nrgt;
  logic            lft_ok, rgt_ok, pick_rgt, dn_swap, up_swap;
  logic            full, empty;

  hpq_cmp u_cmp (
    .key_e (ent_r.key),
    .key_a (mem_rdata_a.key),
    .key_b (mem_rdata_b.key),
    .flags (flags)
  );

  // Child positions of the hole and the sift decisions taken from the compare.
  always_comb begin
    lft      = {1'b0, pos_r, 1'b1};
    rgt      = lft + IW'(1);
    cnt_ext  = IW'(cnt_r);
    lft_ok   = lft < cnt_ext;
    rgt_ok   = rgt < cnt_ext;
    pick_rgt = rgt_ok && !flags.a_lt_b;
    dn_swap  = lft_ok && (pick_rgt ? flags.b_lt_e : flags.a_lt_e);
    up_swap  = (pos_r != '0) && flags.e_lt_a;
    full     = cnt_r == CW'(CAPACITY);
    empty    = cnt_r == '0;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hpq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == hpq_pkg::OP_PUSH) begin
            state_nxt = (full || empty) ? hpq_pkg::S_FINISH : hpq_pkg::S_SIFT_UP;
          end else begin
            state_nxt = empty ? hpq_pkg::S_FINISH : hpq_pkg::S_POP_LOAD;
          end
        end
      end
      hpq_pkg::S_POP_LOAD: begin
        state_nxt = empty ? hpq_pkg::S_FINISH : hpq_pkg::S_SIFT_DN;
      end
      hpq_pkg::S_SIFT_UP: begin
        state_nxt = up_swap ? hpq_pkg::S_SIFT_UP : hpq_pkg::S_FINISH;
      end
      hpq_pkg::S_SIFT_DN: begin
        state_nxt = dn_swap ? hpq_pkg::S_SIFT_DN : hpq_pkg::S_FINISH;
      end
      hpq_pkg::S_FINISH: begin
        state_nxt = out_free ? hpq_pkg::S_IDLE : hpq_pkg::S_FINISH;
      end
      default: state_nxt = hpq_pkg::S_IDLE;
    endcase
  end

  // Next values of the count, the hole position, the moving entry and the result.
  always_comb begin
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    op_nxt      = op_r;
    wr_hole_nxt = wr_hole_r;
    ent_nxt     = ent_r;
    res_nxt     = res_r;
    unique case (state_r)
      hpq_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_op;
          res_nxt     = '{status: hpq_pkg::ST_OK, key: '0, tag: '0,
                          occ: hpq_pkg::OCC_W'(cnt_r)};
          wr_hole_nxt = 1'b1;
          pos_nxt     = '0;
          if (in_op == hpq_pkg::OP_PUSH) begin
            if (full) begin
              res_nxt.status = hpq_pkg::ST_FULL;
              wr_hole_nxt    = 1'b0;
            end else begin
              ent_nxt     = '{key: in_key, tag: in_tag};
              pos_nxt     = AW'(cnt_r);
              cnt_nxt     = cnt_r + CW'(1);
              res_nxt.occ = hpq_pkg::OCC_W'(cnt_r + CW'(1));
            end
          end else begin
            if (empty) begin
              res_nxt.status = hpq_pkg::ST_EMPTY;
              wr_hole_nxt    = 1'b0;
            end else begin
              cnt_nxt     = cnt_r - CW'(1);
              res_nxt.occ = hpq_pkg::OCC_W'(cnt_r - CW'(1));
            end
          end
        end
      end
      hpq_pkg::S_POP_LOAD: begin
        // Root goes out, the last entry becomes the one sifted down.
        res_nxt.key = mem_rdata_a.key;
        res_nxt.tag = mem_rdata_a.tag;
        ent_nxt     = mem_rdata_b;
        if (empty) begin
          wr_hole_nxt = 1'b0;
        end
      end
      hpq_pkg::S_SIFT_UP: begin
        if (up_swap) begin
          pos_nxt = AW'((pos_r - AW'(1)) >> 1);
        end
      end
      hpq_pkg::S_SIFT_DN: begin
        if (dn_swap) begin
          pos_nxt = pick_rgt ? rgt[AW-1:0] : lft[AW-1:0];
        end
      end
      hpq_pkg::S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Children of the next hole, so that the registered read ports return them along with the hole.
  always_comb begin
    nlft = {1'b0, pos_nxt, 1'b1};
    nrgt = nlft + IW'(1);
  end

  // Memory ports and handshake outputs.
  always_comb begin
    in_stall  = state_r != hpq_pkg::S_IDLE;
    res_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = ent_r;
    unique case (state_r)
      hpq_pkg::S_SIFT_UP: begin
        // Parent moves down into the hole.
        mem_we    = up_swap;
        mem_wdata = mem_rdata_a;
      end
      hpq_pkg::S_SIFT_DN: begin
        // Smaller child moves up into the hole.
        mem_we    = dn_swap;
        mem_wdata = pick_rgt ? mem_rdata_b : mem_rdata_a;
      end
      hpq_pkg::S_FINISH: begin
        mem_we   = out_free && wr_hole_r;
        res_load = out_free;
      end
      default: begin
      end
    endcase

    if ((state_r == hpq_pkg::S_IDLE) && (op_nxt == hpq_pkg::OP_POP)) begin
      mem_raddr_a = '0;
      mem_raddr_b = AW'(cnt_r - CW'(1));
    end else if (op_nxt == hpq_pkg::OP_PUSH) begin
      mem_raddr_a = AW'((pos_nxt - AW'(1)) >> 1);
      mem_raddr_b = AW'((pos_nxt - AW'(1)) >> 1);
    end else begin
      mem_raddr_a = nlft[AW-1:0];
      mem_raddr_b = nrgt[AW-1:0];
    end
  end

  assign res = res_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working registers of the item in hand.
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    op_r      <= op_nxt;
    wr_hole_r <= wr_hole_nxt;
    ent_r     <= ent_nxt;
    res_r     <= res_nxt;
  end

endmodule

/* src/binary_min_heap_priority_queue_top.sv */
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Word
// input    | in        | in_valid/in_stall  | in_op, in_key, in_tag
// result   | out       | out_valid/out_stall| out_status, out_key, out_tag, out_occupancy
//
// One word is taken at a time. A push sifts the new entry up, and a pop first loads
// the root and the last entry and then sifts that entry down, level by level (at most
// log2(CAPACITY) levels); a push into an empty heap and a pop of the last entry skip
// the sift, and a refused word goes straight to the final state. Each level is one
// compare and one write through the single write port of the slot memory. Reset clears
// the entry count, so the heap is empty at once with no clearing pass. A stalled result
// register holds the sequencer in its final state until the register frees up.

module binary_min_heap_priority_queue_top #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [hpq_pkg::KEY_W-1:0]  in_key,
  input  logic [hpq_pkg::TAG_W-1:0]  in_tag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hpq_pkg::STAT_W-1:0] out_status,
  output logic [hpq_pkg::KEY_W-1:0]  out_key,
  output logic [hpq_pkg::TAG_W-1:0]  out_tag,
  output logic [hpq_pkg::OCC_W-1:0]  out_occupancy
);

  localparam int AW = $clog2(CAPACITY);

  logic            out_valid_r, out_valid_nxt;
  hpq_pkg::res_t   out_res_r;
  logic            out_free;
  logic            res_load;
  hpq_pkg::res_t   res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr_a, mem_raddr_b;
  hpq_pkg::entry_t mem_wdata, mem_rdata_a, mem_rdata_b;

  hpq_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  hpq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_key      (in_key),
    .in_tag      (in_tag),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  // The result register can take a new word when empty or being drained.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_key       = out_res_r.key;
  assign out_tag       = out_res_r.tag;
  assign out_occupancy = out_res_r.occ;

endmodule

/* src/hpq_chk.sv */
`timescale 1ns / 1ps

module hpq_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [hpq_pkg::STAT_W-1:0] out_status,
  input logic [hpq_pkg::KEY_W-1:0]  out_key,
  input logic [hpq_pkg::TAG_W-1:0]  out_tag,
  input logic [hpq_pkg::OCC_W-1:0]  out_occupancy
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_tag)
      && $stable(out_status) && $stable(out_occupancy))
    else $error("result word changed while stalled");

  // Only one word is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  // Status is always one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == hpq_pkg::ST_OK) || (out_status == hpq_pkg::ST_FULL)
      || (out_status == hpq_pkg::ST_EMPTY))
    else $error("undefined status code");

  // A refused operation returns no entry.
  a_refused_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != hpq_pkg::ST_OK) |-> (out_key == '0) && (out_tag == '0))
    else $error("refused operation returned an entry");

  // A pop is refused as empty only when the heap holds no entries.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == hpq_pkg::ST_EMPTY) |-> out_occupancy == '0)
    else $error("pop refused with entries held");

endmodule

bind binary_min_heap_priority_queue_top hpq_chk u_hpq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_key       (out_key),
  .out_tag       (out_tag),
  .out_occupancy (out_occupancy)
);

/* tb/binary_min_heap_priority_queue_top_test.sv */
`timescale 1ns / 1ps

module binary_min_heap_priority_queue_top_test;

  localparam int KEY_W        = hpq_pkg::KEY_W;
  localparam int TAG_W        = hpq_pkg::TAG_W;
  localparam int STAT_W       = hpq_pkg::STAT_W;
  localparam int OCC_W        = hpq_pkg::OCC_W;
  localparam int HEAP_SLOTS   = hpq_pkg::CAPACITY_DEF;
  localparam int WORDS_TARGET = 750;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              in_op     = hpq_pkg::OP_PUSH;
  logic [KEY_W-1:0]  in_key    = '0;
  logic [TAG_W-1:0]  in_tag    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [KEY_W-1:0]  out_key;
  logic [TAG_W-1:0]  out_tag;
  logic [OCC_W-1:0]  out_occupancy;

  binary_min_heap_priority_queue_top #(
    .CAPACITY(HEAP_SLOTS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key       (in_key),
    .in_tag       (in_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_key      (out_key),
    .out_tag      (out_tag),
    .out_occupancy(out_occupancy)
  );

  // Keeps a private copy of the heap and the result words that it implies.
  class heap_scoreboard;
    bit [KEY_W-1:0] slot_key [HEAP_SLOTS];
    bit [TAG_W-1:0] slot_tag [HEAP_SLOTS];
    int unsigned    fill;
    hpq_pkg::res_t  awaited_words [$];
    int             errors;
    int             pushes, pops, full_refusals, empty_refusals, words_checked;
    int             peak_fill;

    function new();
      fill = 0;
      errors = 0;
      pushes = 0;
      pops = 0;
      full_refusals = 0;
      empty_refusals = 0;
      words_checked = 0;
      peak_fill = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      bit [KEY_W-1:0] k;
      bit [TAG_W-1:0] t;
      k = slot_key[a];
      t = slot_tag[a];
      slot_key[a] = slot_key[b];
      slot_tag[a] = slot_tag[b];
      slot_key[b] = k;
      slot_tag[b] = t;
    endfunction

    // A new entry climbs only while it is strictly below its parent.
    function void sift_toward_root(int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (slot_key[pos] < slot_key[parent]) begin
          swap_slots(pos, parent);
          pos = parent;
        end else begin
          break;
        end
      end
    endfunction

    // The moved entry sinks past the smaller child; on equal children the right one wins.
    function void sift_toward_leaves(int unsigned pos);
      int unsigned lchild, rchild, pick;
      forever begin
        lchild = 2 * pos + 1;
        rchild = lchild + 1;
        if (lchild >= fill) break;
        if (rchild < fill) pick = (slot_key[lchild] < slot_key[rchild]) ? lchild : rchild;
        else pick = lchild;
        if (slot_key[pos] > slot_key[pick]) begin
          swap_slots(pos, pick);
          pos = pick;
        end else begin
          break;
        end
      end
    endfunction

    // Applies one accepted input word and queues the result word it must produce.
    function void note_word(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      hpq_pkg::res_t r;
      r = '0;
      r.status = hpq_pkg::ST_OK;
      if (op == hpq_pkg::OP_PUSH) begin
        pushes++;
        if (fill >= HEAP_SLOTS) begin
          r.status = hpq_pkg::ST_FULL;
          full_refusals++;
        end else begin
          slot_key[fill] = key;
          slot_tag[fill] = tag;
          fill++;
          sift_toward_root(fill - 1);
        end
      end else begin
        pops++;
        if (fill == 0) begin
          r.status = hpq_pkg::ST_EMPTY;
          empty_refusals++;
        end else begin
          r.key = slot_key[0];
          r.tag = slot_tag[0];
          fill--;
          if (fill > 0) begin
            slot_key[0] = slot_key[fill];
            slot_tag[0] = slot_tag[fill];
            sift_toward_leaves(0);
          end
        end
      end
      r.occ = OCC_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      awaited_words.insert(awaited_words.size(), r);
    endfunction

    function int awaited();
      return awaited_words.size();
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns ERROR %s", $time, msg);
      errors++;
    endtask

    // Compares one result word with the oldest awaited one, field by field.
    task check_word(logic [STAT_W-1:0] status, logic [KEY_W-1:0] key,
                    logic [TAG_W-1:0] tag, logic [OCC_W-1:0] occ);
      hpq_pkg::res_t want;
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("result word with none awaited: status %0d key %h",
                                  status, key));
      end else begin
        want = awaited_words.pop_front();
        words_checked++;
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (key !== want.key)
          report_mismatch($sformatf("key got %h want %h", key, want.key));
        if (tag !== want.tag)
          report_mismatch($sformatf("tag got %h want %h", tag, want.tag));
        if (occ !== want.occ)
          report_mismatch($sformatf("occupancy got %0d want %0d", occ, want.occ));
      end
    endtask
  endclass

  heap_scoreboard sb;
  int             burst_left = 0;
  logic [7:0]     stall_pattern = '0;
  int             stall_span = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Keys mix wide random values, a tiny set that forces ties, extremes and packed names.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               n;
    k = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = {$urandom, $urandom};
      4, 5: k = KEY_W'($urandom_range(0, 7));
      6: begin
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = '1;
          2: k = KEY_W'(1);
          default: k = {KEY_W{1'b1}} - 1;
        endcase
      end
      default: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) k[KEY_W-1-8*i -: 8] = 8'($urandom_range(8'h61, 8'h7a));
      end
    endcase
    return k;
  endfunction

  // Sends one word, opening a fresh burst after a random gap when the last one ran out.
  task automatic send_word(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    in_tag   <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, key, tag);
    burst_left--;
  endtask

  task automatic send_push(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    send_word(hpq_pkg::OP_PUSH, key, tag);
  endtask

  // Key and tag are ignored on a pop, so they carry noise.
  task automatic send_pop();
    send_word(hpq_pkg::OP_POP, {$urandom, $urandom}, TAG_W'($urandom));
  endtask

  // Receiver back-pressure: a rotating mask, never all ones, reloaded now and then.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span    <= $urandom_range(16, 96);
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'h00 : {1'b0, 7'($urandom)};
      out_stall     <= 1'b0;
    end else begin
      stall_span    <= stall_span - 1;
      stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      out_stall     <= stall_pattern[0];
    end
  end

  // Every result word taken is checked against the oldest awaited one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_status, out_key, out_tag, out_occupancy);
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int mode;
    int span;
    int push_pct;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, extreme keys and tags, ties, draining to empty.
    send_pop();
    send_push('0, '0);
    send_push('1, '1);
    send_push(KEY_W'(5), TAG_W'(1));
    send_push(KEY_W'(5), TAG_W'(2));
    send_push(KEY_W'(5), TAG_W'(3));
    send_push(64'h8000_0000_0000_0000, 16'h8000);
    send_push(KEY_W'(5), TAG_W'(4));
    repeat (7) send_pop();
    send_pop();
    // Packed names that share a prefix, then their lexicographic order back out.
    send_push(64'h6170_706c_7900_0000, 16'h0001);
    send_push(64'h6170_706c_6500_0000, 16'h0002);
    send_push(64'h6170_6500_0000_0000, 16'h0003);
    repeat (3) send_pop();

    // Fill beyond capacity so pushes are refused, then drain beyond empty.
    repeat (HEAP_SLOTS + 3) send_push(pick_key(), TAG_W'($urandom));
    repeat (HEAP_SLOTS + 2) send_pop();

    // Random phases that lean towards filling, draining or an even mix.
    while (sb.pushes + sb.pops < WORDS_TARGET) begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(16, 96);
      if (span > WORDS_TARGET - (sb.pushes + sb.pops)) begin
        span = WORDS_TARGET - (sb.pushes + sb.pops);
      end
      case (mode)
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (span) begin
        if ($urandom_range(0, 99) < push_pct) send_push(pick_key(), TAG_W'($urandom));
        else send_pop();
      end
    end
    in_valid <= 1'b0;

    while (sb.awaited() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pushes (%0d refused as full) and %0d pops (%0d refused as empty).",
             sb.pushes, sb.full_refusals, sb.pops, sb.empty_refusals);
    $display("Checked %0d result words; occupancy peaked at %0d of %0d slots.",
             sb.words_checked, sb.peak_fill, HEAP_SLOTS);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
